>>> design/aligned_stack_allocator_unit_assert.svh
// Assertion macros shared by the allocator modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
// The check is switched off while reset is asserted.
`ifndef ALIGNED_STACK_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASAU_ASSERT_IMPL(label, ante, cons, msg)
`define ASAU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> design/asau_pkg.sv
package asau_pkg;

    // Fixed field widths.
    localparam int POS_W    = 32;
    localparam int BYTES_W  = 25;
    localparam int ALIGN_W  = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int NEED_W   = BYTES_W + 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Parameter defaults.
    localparam int ADDR_BITS_DEFAULT = 32;
    localparam int MAX_ALIGN_DEFAULT = 128;

    // Register reset values.
    localparam logic [POS_W-1:0]   BASE_RESET   = 32'h0000_0000;
    localparam logic [BYTES_W-1:0] REGION_RESET = 25'd65536;
    localparam logic               GROW_RESET   = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_MARKER  = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_MEMORY  = 2'd1,
        STATUS_BAD_MARKER = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_REGION_BYTES = 2'd1,
        CFG_GROW_UPWARDS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]   base;
        logic [BYTES_W-1:0] region;
        logic               grow_up;
    } cfg_t;

    typedef struct packed {
        func_t              func;
        logic [BYTES_W-1:0] size;
        logic [ALIGN_W-1:0] align;
        logic [POS_W-1:0]   mark_pos;
        logic [BYTES_W-1:0] mark_cnt;
        logic [BYTES_W-1:0] partner;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   block;
        logic [POS_W-1:0]   position;
        logic [BYTES_W-1:0] count;
        logic [BYTES_W-1:0] used;
    } result_t;

    // Mask of the largest power of two that does not exceed v (at most 128), minus one.
    function automatic logic [ALIGN_W-1:0] cap_mask(input int v);
        logic [ALIGN_W-1:0] m;
        m = '0;
        for (int i = 1; i < ALIGN_W; i++) begin
            if ((1 << i) <= v) begin
                m = ALIGN_W'((1 << i) - 1);
            end
        end
        return m;
    endfunction

    // Alignment minus one: the highest set bit of a, zero acting as one.
    function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
        logic [ALIGN_W-1:0] s;
        s = a | (a >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        return s >> 1;
    endfunction

endpackage

>>> design/asau_cfg.sv
module asau_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [asau_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asau_pkg::CFG_DATA_W-1:0]  cfg_data,
    output asau_pkg::cfg_t                 cfg,
    output asau_pkg::cfg_t                 cfg_next,
    output logic                           cfg_load
);
    import asau_pkg::*;

    cfg_t cfg_reg;

    // Decode a register write; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_load = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BASE_ADDRESS:
                begin
                    cfg_next.base = cfg_data[POS_W-1:0];
                    cfg_load      = 1'b1;
                end
                CFG_REGION_BYTES:
                begin
                    cfg_next.region = cfg_data[BYTES_W-1:0];
                    cfg_load        = 1'b1;
                end
                CFG_GROW_UPWARDS:
                begin
                    cfg_next.grow_up = cfg_data[0];
                    cfg_load         = 1'b1;
                end
                default:
                begin
                    cfg_load = 1'b0;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base    <= BASE_RESET;
            cfg_reg.region  <= REGION_RESET;
            cfg_reg.grow_up <= GROW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/asau_exec.sv
`include "aligned_stack_allocator_unit_assert.svh"

module asau_exec #(
    parameter int ADDR_BITS = asau_pkg::ADDR_BITS_DEFAULT,
    parameter int MAX_ALIGN = asau_pkg::MAX_ALIGN_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  asau_pkg::cfg_t    cfg,
    input  asau_pkg::cfg_t    cfg_next,
    input  logic              cfg_load,
    input  logic              fire,
    input  asau_pkg::req_t    req,
    output asau_pkg::result_t res
);
    import asau_pkg::*;

    // Working width that holds both an address and a 32-bit field.
    localparam int W = (ADDR_BITS > POS_W) ? ADDR_BITS : POS_W;
    localparam logic [ALIGN_W-1:0] CAP_MASK = cap_mask(MAX_ALIGN);
    localparam logic [W-1:0] RST_BASE_W   = W'(BASE_RESET);
    localparam logic [W-1:0] RST_REGION_W = W'(REGION_RESET);
    localparam logic [W-1:0] RST_END_W    = RST_BASE_W + RST_REGION_W;
    localparam logic [ADDR_BITS-1:0] RESET_ORIGIN =
        GROW_RESET ? RST_BASE_W[ADDR_BITS-1:0] : RST_END_W[ADDR_BITS-1:0];

    logic [ADDR_BITS-1:0] top_reg, top_next;
    logic [BYTES_W-1:0]   used_reg, used_next;
    logic [BYTES_W-1:0]   cnt_reg, cnt_next;

    logic [W-1:0]         base_w, end_w, nbase_w, nend_w, mark_w, size_w;
    logic [ADDR_BITS-1:0] origin, init_origin, mark_a, size_a;
    logic [ALIGN_W-1:0]   mask, pad_up, pad_dn, pad;
    logic [ADDR_BITS-1:0] pad_a, diff_dn, blk_up, top_up, blk_dn;
    logic [NEED_W-1:0]    need;
    logic                 no_room;
    logic [ADDR_BITS-1:0] mark_dist;
    logic [W-1:0]         dist_w, used_w, blk_w, pos_w;

    logic [ADDR_BITS-1:0] s_top, s_blk;
    logic [BYTES_W-1:0]   s_used, s_cnt;
    status_t              s_status;

    // Stack origins for the current and the incoming configuration.
    always_comb
    begin
        base_w      = W'(cfg.base);
        end_w       = base_w + W'(cfg.region);
        origin      = cfg.grow_up ? base_w[ADDR_BITS-1:0] : end_w[ADDR_BITS-1:0];
        nbase_w     = W'(cfg_next.base);
        nend_w      = nbase_w + W'(cfg_next.region);
        init_origin = cfg_next.grow_up ? nbase_w[ADDR_BITS-1:0] : nend_w[ADDR_BITS-1:0];
    end

    // Allocate path: alignment padding, room check and new block.
    always_comb
    begin
        size_w  = W'(req.size);
        size_a  = size_w[ADDR_BITS-1:0];
        mask    = align_mask(req.align) & CAP_MASK;
        pad_up  = (ALIGN_W'(0) - top_reg[ALIGN_W-1:0]) & mask;
        diff_dn = top_reg - size_a;
        pad_dn  = diff_dn[ALIGN_W-1:0] & mask;
        pad     = cfg.grow_up ? pad_up : pad_dn;
        pad_a   = {{(ADDR_BITS-ALIGN_W){1'b0}}, pad};
        need    = NEED_W'(req.partner) + NEED_W'(used_reg) + NEED_W'(pad)
                + NEED_W'(req.size);
        no_room = need > NEED_W'(cfg.region);
        blk_up  = top_reg + pad_a;
        top_up  = blk_up + size_a;
        blk_dn  = diff_dn - pad_a;
    end

    // Release path: distance of the marker from the origin.
    always_comb
    begin
        mark_w    = W'(req.mark_pos);
        mark_a    = mark_w[ADDR_BITS-1:0];
        mark_dist = cfg.grow_up ? (mark_a - origin) : (origin - mark_a);
        dist_w    = W'(mark_dist);
        used_w    = W'(used_reg);
    end

    // Outcome of one request.
    always_comb
    begin
        s_top    = top_reg;
        s_used   = used_reg;
        s_cnt    = cnt_reg;
        s_blk    = '0;
        s_status = STATUS_OK;
        case (req.func)
            FUNC_ALLOC:
            begin
                if (no_room)
                begin
                    s_status = STATUS_NO_MEMORY;
                end
                else
                begin
                    s_blk  = cfg.grow_up ? blk_up : blk_dn;
                    s_top  = cfg.grow_up ? top_up : blk_dn;
                    s_used = used_reg + BYTES_W'(pad) + req.size;
                    s_cnt  = cnt_reg + BYTES_W'(1);
                end
            end
            FUNC_MARKER:
            begin
                s_status = STATUS_OK;
            end
            FUNC_RELEASE:
            begin
                if (dist_w > used_w)
                begin
                    s_status = STATUS_BAD_MARKER;
                end
                else
                begin
                    s_top  = mark_a;
                    s_used = dist_w[BYTES_W-1:0];
                    s_cnt  = req.mark_cnt;
                end
            end
            FUNC_CLEAR:
            begin
                s_top  = origin;
                s_used = '0;
                s_cnt  = '0;
            end
            default:
            begin
                s_status = STATUS_OK;
            end
        endcase
    end

    // A register write restarts the stack; otherwise a request updates it.
    always_comb
    begin
        top_next  = top_reg;
        used_next = used_reg;
        cnt_next  = cnt_reg;
        if (cfg_load)
        begin
            top_next  = init_origin;
            used_next = '0;
            cnt_next  = '0;
        end
        else if (fire)
        begin
            top_next  = s_top;
            used_next = s_used;
            cnt_next  = s_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= RESET_ORIGIN;
            used_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            used_reg <= used_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Result fields reflect the state after the request.
    always_comb
    begin
        blk_w        = W'(s_blk);
        pos_w        = W'(s_top);
        res.status   = s_status;
        res.block    = blk_w[POS_W-1:0];
        res.position = pos_w[POS_W-1:0];
        res.count    = s_cnt;
        res.used     = s_used;
    end

    `ASAU_ASSERT_NEXT(a_refused_keeps_state, fire && !cfg_load && res.status != STATUS_OK, $stable(top_reg) && $stable(used_reg) && $stable(cnt_reg), "refused request changed the stack")
    `ASAU_ASSERT_IMPL(a_used_fits_region, 1'b1, used_reg <= cfg.region, "used bytes exceed the region")
    `ASAU_ASSERT_NEXT(a_clear_empties, fire && !cfg_load && req.func == FUNC_CLEAR, used_reg == '0 && cnt_reg == '0, "clear left the stack in use")

endmodule

>>> design/aligned_stack_allocator_unit.sv
// Aligned stack allocator.
// Requests enter on the input channel (in_valid / in_stall) with a function
// code: allocate, read marker, release to marker or clear. Every request
// returns exactly one result on the output channel (out_valid / out_stall)
// with the status, the block address and the stack state after the request.
// The request is captured in an input register, evaluated in one pass of
// adds, an alignment mask and compares against the stack registers, and the
// result lands in an output register that drives out_valid. One request
// per cycle is sustained while the receiver does not raise out_stall.
// Registers base_address, region_bytes and grow_upwards are written through
// cfg_write / cfg_index / cfg_data, by the user only while no request is in
// flight, which the block does not enforce; each write restarts the stack.
// Reset restores the register defaults and an empty stack at the base.
// While the receiver stalls, the output register holds its result; one more
// request may still be taken into the input register, after which in_stall
// rises until the output drains.
`include "aligned_stack_allocator_unit_assert.svh"

module aligned_stack_allocator_unit #(
    parameter int ADDR_BITS = asau_pkg::ADDR_BITS_DEFAULT,
    parameter int MAX_ALIGN = asau_pkg::MAX_ALIGN_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_write,
    input  logic [asau_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asau_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [asau_pkg::FUNC_W-1:0]      func,
    input  logic [asau_pkg::BYTES_W-1:0]     request_bytes,
    input  logic [asau_pkg::ALIGN_W-1:0]     align_bytes,
    input  logic [asau_pkg::POS_W-1:0]       mark_position,
    input  logic [asau_pkg::BYTES_W-1:0]     mark_count,
    input  logic [asau_pkg::BYTES_W-1:0]     partner_used,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [asau_pkg::STATUS_W-1:0]    status,
    output logic [asau_pkg::POS_W-1:0]       block_address,
    output logic [asau_pkg::POS_W-1:0]       current_position,
    output logic [asau_pkg::BYTES_W-1:0]     allocation_total,
    output logic [asau_pkg::BYTES_W-1:0]     used_total
);
    import asau_pkg::*;

    cfg_t    cfg, cfg_next;
    logic    cfg_load;

    logic    in_vld_reg, in_vld_next;
    req_t    req_reg;
    logic    out_vld_reg, out_vld_next;
    result_t res_reg, res;
    logic    in_take, advance;

    asau_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_next  (cfg_next),
        .cfg_load  (cfg_load)
    );

    asau_exec #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_ALIGN (MAX_ALIGN)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_next (cfg_next),
        .cfg_load (cfg_load),
        .fire     (advance),
        .req      (req_reg),
        .res      (res)
    );

    // Handshake: the held request moves on whenever the output register is free.
    always_comb
    begin
        advance      = in_vld_reg && (!out_vld_reg || !out_stall);
        in_stall     = in_vld_reg && !advance;
        in_take      = in_valid && !in_stall;
        in_vld_next  = in_take || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.func     <= func_t'(func);
            req_reg.size     <= request_bytes;
            req_reg.align    <= align_bytes;
            req_reg.mark_pos <= mark_position;
            req_reg.mark_cnt <= mark_count;
            req_reg.partner  <= partner_used;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid        = out_vld_reg;
    assign status           = res_reg.status;
    assign block_address    = res_reg.block;
    assign current_position = res_reg.position;
    assign allocation_total = res_reg.count;
    assign used_total       = res_reg.used;

    `ASAU_ASSERT_IMPL(a_stall_needs_held_request, in_stall, in_vld_reg && out_vld_reg, "stall raised with no request held")
    `ASAU_ASSERT_NEXT(a_held_request_moves, in_vld_reg && !out_vld_reg, out_vld_reg, "held request did not reach the output")
    `ASAU_ASSERT_NEXT(a_output_drains, out_vld_reg && !out_stall && !in_vld_reg, !out_vld_reg, "taken result was repeated")

endmodule
